// File: rtl/core/mls_pkg.sv
// Package: sizes, codes and command word shared by the list store modules.
`timescale 1ns / 1ps
`default_nettype none
package mls_pkg;
	localparam int NUM_LISTS  = 10;
	localparam int MAX_CAP    = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CNT_W  = $clog2(MAX_CAP + 1);
	localparam int DEPTH  = NUM_LISTS * MAX_CAP;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] F_CREATE = 3'd0;
	localparam logic [2:0] F_APPEND = 3'd1;
	localparam logic [2:0] F_DROP   = 3'd2;
	localparam logic [2:0] F_DELETE = 3'd3;
	localparam logic [2:0] F_RESIZE = 3'd4;
	localparam logic [2:0] F_COUNT  = 3'd5;
	localparam logic [2:0] F_READ   = 3'd6;
	localparam logic [2:0] F_SORTED = 3'd7;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_BAD_POS   = 4'd1;
	localparam logic [3:0] ST_EXISTS    = 4'd2;
	localparam logic [3:0] ST_NO_MEM    = 4'd3;
	localparam logic [3:0] ST_BAD_SIZE  = 4'd4;
	localparam logic [3:0] ST_FULL      = 4'd5;
	localparam logic [3:0] ST_NO_LIST   = 4'd6;
	localparam logic [3:0] ST_EMPTY     = 4'd7;
	localparam logic [3:0] ST_NOT_FOUND = 4'd8;
	localparam logic [3:0] ST_BAD_NEW   = 4'd9;

	typedef struct packed {
		logic                  bad_pos;
		logic [2:0]            func;
		logic [IDX_W-1:0]      idx;
		logic signed [6:0]     amount;
		logic [DATA_WIDTH-1:0] value;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] idx,
			input logic [CNT_W-1:0] i);
		return ADDR_W'(idx) * ADDR_W'(MAX_CAP) + ADDR_W'(i);
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/mls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/mls_front.sv
// Front end: takes input words, checks the list number and builds commands.
`timescale 1ns / 1ps
`default_nettype none
module mls_front import mls_pkg::*; (
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [3:0]  list_position,
	input  wire logic signed [6:0]  amount,
	input  wire logic signed [31:0] value,
	output logic             push,
	output cmd_t             cmd,
	input  wire logic        q_full
);
	logic             bad;
	logic [DATA_WIDTH-1:0] wv;

	always_comb begin
		bad = (list_position == 4'd0) || (int'(list_position) > NUM_LISTS);
		for (int b = 0; b < DATA_WIDTH; b++) begin
			wv[b] = (b < 32) ? value[(b < 32) ? b : 31] : value[31];
		end
		cmd.bad_pos = bad;
		cmd.func    = func;
		cmd.idx     = bad ? '0 : IDX_W'(list_position - 4'd1);
		cmd.amount  = amount;
		cmd.value   = wv;
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
endmodule
`default_nettype wire

// File: rtl/core/mls_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module mls_queue import mls_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output cmd_t      head
);
	cmd_t ent_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_cmd;
	end
endmodule
`default_nettype wire

// File: rtl/core/mls_back.sv
// Back end: list tables, element RAM walks and the output register.
`timescale 1ns / 1ps
`default_nettype none
module mls_back import mls_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  cmd_t      q_cmd,
	output logic      q_pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [3:0]  status,
	output logic        item_valid,
	output logic [31:0] read_value,
	output logic [4:0]  fill_count,
	output logic        last
);
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DEC  = 7'b0000010,
		S_RD   = 7'b0000100,
		S_CHK  = 7'b0001000,
		S_SHR  = 7'b0010000,
		S_SHW  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t state_q, ret_q;
	cmd_t   cmd_q;
	logic             pres_q [NUM_LISTS];
	logic [CNT_W-1:0] cap_q  [NUM_LISTS];
	logic [CNT_W-1:0] fill_q [NUM_LISTS];
	logic [CNT_W-1:0] n_q, i_q, j_q, k_q, bidx_q, pidx_q;
	logic signed [DATA_WIDTH-1:0] best_q, prev_q;
	logic found_q;
	logic [3:0]  pend_st_q;
	logic        pend_iv_q, pend_last_q;
	logic [31:0] pend_val_q;
	logic [CNT_W-1:0] pend_fill_q;
	logic out_valid_q;

	logic we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [DATA_WIDTH-1:0] wdata, rdata;
	logic             cur_pres;
	logic [CNT_W-1:0] cur_cap, cur_fill, inext;
	logic signed [DATA_WIDTH-1:0] cand, nbest;
	logic [CNT_W-1:0] nbidx;
	logic take, out_free;
	int   newcap;

	mls_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [31:0] to32(input logic [DATA_WIDTH-1:0] w);
		logic [31:0] r;
		for (int b = 0; b < 32; b++) begin
			r[b] = (b < DATA_WIDTH) ? w[(b < DATA_WIDTH) ? b : 0] : 1'b0;
		end
		return r;
	endfunction

	always_comb begin
		cur_pres = pres_q[cmd_q.idx];
		cur_cap  = cap_q[cmd_q.idx];
		cur_fill = fill_q[cmd_q.idx];
		inext    = i_q + CNT_W'(1);
		newcap   = int'(cur_cap) + int'(cmd_q.amount);
		out_free = !out_valid_q || out_ready;
		cand     = $signed(rdata);
		take = ((k_q == '0) || (cand > prev_q) || (cand == prev_q && i_q > pidx_q))
			&& (!found_q || cand < best_q);
		nbest = take ? cand : best_q;
		nbidx = take ? i_q : bidx_q;
		we    = 1'b0;
		waddr = elem_addr(cmd_q.idx, j_q);
		wdata = rdata;
		raddr = elem_addr(cmd_q.idx, i_q);
		if (state_q == S_DEC && !cmd_q.bad_pos && cmd_q.func == F_APPEND && cur_pres
				&& cur_fill < cur_cap) begin
			we    = 1'b1;
			waddr = elem_addr(cmd_q.idx, cur_fill);
			wdata = cmd_q.value;
		end else if (state_q == S_SHW) begin
			we = 1'b1;
		end
		if (state_q == S_SHR) raddr = elem_addr(cmd_q.idx, j_q + CNT_W'(1));
	end

	assign q_pop = state_q == S_IDLE && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int l = 0; l < NUM_LISTS; l++) begin
				pres_q[l] <= 1'b0;
				cap_q[l]  <= '0;
				fill_q[l] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_DEC;
				S_DEC: begin
					state_q <= S_EMIT;
					ret_q   <= S_IDLE;
					pend_iv_q   <= 1'b0;
					pend_val_q  <= '0;
					pend_last_q <= 1'b1;
					pend_fill_q <= cur_fill;
					pend_st_q   <= ST_OK;
					n_q <= cur_fill;
					i_q <= '0;
					k_q <= '0;
					found_q <= 1'b0;
					if (cmd_q.bad_pos) begin
						pend_st_q   <= ST_BAD_POS;
						pend_fill_q <= '0;
					end else if (cmd_q.func == F_CREATE) begin
						if (cur_pres) begin
							pend_st_q <= ST_EXISTS;
						end else begin
							pend_fill_q <= '0;
							if (cmd_q.amount < 7'sd1) begin
								pend_st_q <= ST_BAD_SIZE;
							end else if (int'(cmd_q.amount) > MAX_CAP) begin
								pend_st_q <= ST_NO_MEM;
							end else begin
								pres_q[cmd_q.idx] <= 1'b1;
								cap_q[cmd_q.idx]  <= CNT_W'(cmd_q.amount);
								fill_q[cmd_q.idx] <= '0;
							end
						end
					end else if (!cur_pres) begin
						pend_st_q   <= ST_NO_LIST;
						pend_fill_q <= '0;
					end else begin
						unique case (cmd_q.func)
							F_APPEND: begin
								if (cur_fill < cur_cap) begin
									fill_q[cmd_q.idx] <= cur_fill + CNT_W'(1);
									pend_fill_q <= cur_fill + CNT_W'(1);
								end else begin
									pend_st_q <= ST_FULL;
								end
							end
							F_DROP: begin
								if (cur_fill == '0) begin
									pend_st_q <= ST_EMPTY;
								end else begin
									fill_q[cmd_q.idx] <= cur_fill - CNT_W'(1);
									pend_fill_q <= cur_fill - CNT_W'(1);
								end
							end
							F_RESIZE: begin
								if (newcap < 1) begin
									pend_st_q <= ST_BAD_NEW;
								end else if (newcap > MAX_CAP) begin
									pend_st_q <= ST_NO_MEM;
								end else begin
									cap_q[cmd_q.idx] <= CNT_W'(newcap);
									if (int'(cur_fill) > newcap) begin
										fill_q[cmd_q.idx] <= CNT_W'(newcap);
										pend_fill_q <= CNT_W'(newcap);
									end
								end
							end
							F_COUNT: if (cur_fill == '0) pend_st_q <= ST_EMPTY;
							F_DELETE: begin
								if (cur_fill == '0) pend_st_q <= ST_EMPTY;
								else state_q <= S_RD;
							end
							F_READ, F_SORTED: if (cur_fill != '0) state_q <= S_RD;
							default: pend_st_q <= ST_OK;
						endcase
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					state_q <= S_RD;
					i_q     <= inext;
					if (cmd_q.func == F_DELETE) begin
						if (rdata == cmd_q.value) begin
							j_q <= i_q;
							if (inext < n_q) begin
								state_q <= S_SHR;
							end else begin
								fill_q[cmd_q.idx] <= n_q - CNT_W'(1);
								pend_fill_q <= n_q - CNT_W'(1);
								state_q <= S_EMIT;
							end
						end else if (inext >= n_q) begin
							pend_st_q <= ST_NOT_FOUND;
							state_q   <= S_EMIT;
						end
					end else if (cmd_q.func == F_READ) begin
						pend_iv_q   <= 1'b1;
						pend_val_q  <= to32(rdata);
						pend_last_q <= inext == n_q;
						ret_q   <= (inext == n_q) ? S_IDLE : S_RD;
						state_q <= S_EMIT;
					end else begin
						best_q  <= nbest;
						bidx_q  <= nbidx;
						found_q <= found_q || take;
						if (inext >= n_q) begin
							pend_iv_q   <= 1'b1;
							pend_val_q  <= to32(nbest);
							pend_last_q <= (k_q + CNT_W'(1)) == n_q;
							ret_q   <= ((k_q + CNT_W'(1)) == n_q) ? S_IDLE : S_RD;
							state_q <= S_EMIT;
							prev_q  <= nbest;
							pidx_q  <= nbidx;
							k_q     <= k_q + CNT_W'(1);
							i_q     <= '0;
							found_q <= 1'b0;
						end
					end
				end
				S_SHR: state_q <= S_SHW;
				S_SHW: begin
					j_q <= j_q + CNT_W'(1);
					if (j_q + CNT_W'(2) < n_q) begin
						state_q <= S_SHR;
					end else begin
						fill_q[cmd_q.idx] <= n_q - CNT_W'(1);
						pend_fill_q <= n_q - CNT_W'(1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status      <= pend_st_q;
						item_valid  <= pend_iv_q;
						read_value  <= pend_val_q;
						fill_count  <= 5'(pend_fill_q);
						last        <= pend_last_q;
						state_q     <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
	end

	assign out_valid = out_valid_q;

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_DEC || state_q == S_SHW))
		else $error("RAM write outside decode or shift");
	a_load_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q ##1 out_valid_q) |-> $past(state_q) == S_EMIT)
		else $error("result loaded outside emit");
	a_item_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && item_valid) |-> status == ST_OK)
		else $error("element word with error status");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == S_DEC)
		else $error("command popped without decode");
endmodule
`default_nettype wire

// File: rtl/core/multi_list_store_top.sv
// Top level of the numbered list store: front, command queue and back end.
// channel | signals                                          | dir
// in      | in_valid in_ready func list_position amount value | word in
// out     | out_valid out_ready status item_valid read_value  | word out
//         | fill_count last                                  |
// Single-result operations pass decode and emit from queue head to output register.
// Read: RAM read, check, emit per element; delete: read, check per element scanned,
// shift per element moved; sorted: a list scan per element out (one RAM read port).
// Reset clears list tables and control; element RAM needs no clearing.
// The two-entry queue keeps taking words while the back end or output stalls, until it is full.
`timescale 1ns / 1ps
`default_nettype none
module multi_list_store_top import mls_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [3:0]  list_position,
	input  wire logic signed [6:0]  amount,
	input  wire logic signed [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic             item_valid,
	output logic signed [31:0] read_value,
	output logic [4:0]       fill_count,
	output logic             last
);
	cmd_t f_cmd, q_head;
	logic push, q_full, q_ne, pop;
	logic [31:0] rv;

	mls_front u_front (
		.in_valid(in_valid), .in_ready(in_ready), .func(func),
		.list_position(list_position), .amount(amount), .value(value),
		.push(push), .cmd(f_cmd), .q_full(q_full)
	);

	mls_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(f_cmd), .full(q_full),
		.pop(pop), .not_empty(q_ne), .head(q_head)
	);

	mls_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_ne), .q_cmd(q_head), .q_pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.item_valid(item_valid), .read_value(rv), .fill_count(fill_count), .last(last)
	);

	assign read_value = $signed(rv);
endmodule
`default_nettype wire

// File: test/multi_list_store_top_test.sv
// Self-checking testbench of the numbered list store: predicted words against the output channel.
`timescale 1ns / 1ps
module multi_list_store_top_test;
	import mls_pkg::*;

	typedef struct packed {
		logic [3:0]  status;
		logic        item_valid;
		logic [31:0] read_value;
		logic [4:0]  fill_count;
		logic        last;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] func = F_CREATE;
	logic [3:0] list_position = '0;
	logic signed [6:0] amount = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] status;
	logic item_valid;
	logic signed [31:0] read_value;
	logic [4:0] fill_count;
	logic last;

	multi_list_store_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .list_position(list_position), .amount(amount), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .item_valid(item_valid), .read_value(read_value),
		.fill_count(fill_count), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the list tables
	logic        shadow_present [NUM_LISTS];
	int          shadow_cap [NUM_LISTS];
	int          shadow_fill [NUM_LISTS];
	logic [31:0] shadow_elems [NUM_LISTS][MAX_CAP];

	result_word_t pending_results [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	function automatic result_word_t make_word(input logic [3:0] st, input logic iv,
			input logic [31:0] rv, input int fc, input logic lst);
		result_word_t w;
		w.status = st;
		w.item_valid = iv;
		w.read_value = rv;
		w.fill_count = 5'(fc);
		w.last = lst;
		return w;
	endfunction

	task automatic predict_op(input logic [2:0] f, input logic [3:0] pos,
			input logic signed [6:0] amt, input logic [31:0] v);
		int idx, n, newcap, hit, i, j;
		logic [31:0] tmp [MAX_CAP];
		logic [31:0] key;
		if (pos < 1 || pos > NUM_LISTS) begin
			pending_results.push_back(make_word(ST_BAD_POS, 0, 0, 0, 1));
			return;
		end
		idx = pos - 1;
		if (f == F_CREATE) begin
			if (shadow_present[idx])
				pending_results.push_back(make_word(ST_EXISTS, 0, 0, shadow_fill[idx], 1));
			else if (amt < 1)
				pending_results.push_back(make_word(ST_BAD_SIZE, 0, 0, 0, 1));
			else if (amt > MAX_CAP)
				pending_results.push_back(make_word(ST_NO_MEM, 0, 0, 0, 1));
			else begin
				shadow_present[idx] = 1;
				shadow_cap[idx] = amt;
				shadow_fill[idx] = 0;
				pending_results.push_back(make_word(ST_OK, 0, 0, 0, 1));
			end
			return;
		end
		if (!shadow_present[idx]) begin
			pending_results.push_back(make_word(ST_NO_LIST, 0, 0, 0, 1));
			return;
		end
		n = shadow_fill[idx];
		case (f)
			F_APPEND: begin
				if (n < shadow_cap[idx]) begin
					shadow_elems[idx][n] = v;
					shadow_fill[idx] = n + 1;
					pending_results.push_back(make_word(ST_OK, 0, 0, n + 1, 1));
				end else
					pending_results.push_back(make_word(ST_FULL, 0, 0, n, 1));
			end
			F_DROP: begin
				if (n == 0)
					pending_results.push_back(make_word(ST_EMPTY, 0, 0, 0, 1));
				else begin
					shadow_fill[idx] = n - 1;
					pending_results.push_back(make_word(ST_OK, 0, 0, n - 1, 1));
				end
			end
			F_DELETE: begin
				if (n == 0)
					pending_results.push_back(make_word(ST_EMPTY, 0, 0, 0, 1));
				else begin
					hit = -1;
					for (i = 0; i < n; i++)
						if (hit < 0 && shadow_elems[idx][i] == v)
							hit = i;
					if (hit < 0)
						pending_results.push_back(make_word(ST_NOT_FOUND, 0, 0, n, 1));
					else begin
						for (j = hit; j + 1 < n; j++)
							shadow_elems[idx][j] = shadow_elems[idx][j + 1];
						shadow_fill[idx] = n - 1;
						pending_results.push_back(make_word(ST_OK, 0, 0, n - 1, 1));
					end
				end
			end
			F_RESIZE: begin
				newcap = shadow_cap[idx] + amt;
				if (newcap < 1)
					pending_results.push_back(make_word(ST_BAD_NEW, 0, 0, n, 1));
				else if (newcap > MAX_CAP)
					pending_results.push_back(make_word(ST_NO_MEM, 0, 0, n, 1));
				else begin
					shadow_cap[idx] = newcap;
					if (n > newcap)
						shadow_fill[idx] = newcap;
					pending_results.push_back(make_word(ST_OK, 0, 0, shadow_fill[idx], 1));
				end
			end
			F_COUNT:
				pending_results.push_back(make_word(n == 0 ? ST_EMPTY : ST_OK, 0, 0, n, 1));
			default: begin
				if (n == 0)
					pending_results.push_back(make_word(ST_OK, 0, 0, 0, 1));
				else begin
					for (i = 0; i < n; i++)
						tmp[i] = shadow_elems[idx][i];
					if (f == F_SORTED)
						for (i = 1; i < n; i++) begin
							key = tmp[i];
							j = i;
							while (j > 0 && $signed(tmp[j - 1]) > $signed(key)) begin
								tmp[j] = tmp[j - 1];
								j--;
							end
							tmp[j] = key;
						end
					for (i = 0; i < n; i++)
						pending_results.push_back(make_word(ST_OK, 1, tmp[i], n, i == n - 1));
				end
			end
		endcase
	endtask

	// drives one word, waits for acceptance; prediction is made at acceptance.
	// valid drops only on an idle cycle, so a following word can go back to back.
	task automatic send_word(input logic [2:0] f, input logic [3:0] pos,
			input logic signed [6:0] amt, input logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		func <= f;
		list_position <= pos;
		amount <= amt;
		value <= v;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_op(f, pos, amt, v);
		@(negedge clk);
	endtask

	// receiver stalls at random
	always @(negedge clk)
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) begin
			result_word_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word status", status, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (item_valid !== want.item_valid)
					report_mismatch("item_valid", item_valid, want.item_valid);
				if (want.item_valid && read_value !== want.read_value)
					report_mismatch("read_value", read_value, want.read_value);
				if (fill_count !== want.fill_count)
					report_mismatch("fill_count", fill_count, want.fill_count);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end

	function automatic logic [31:0] pick_value(input int list_idx);
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($urandom_range(6)) - 32'd3;
			3: if (shadow_present[list_idx] && shadow_fill[list_idx] > 0)
				return shadow_elems[list_idx][$urandom_range(shadow_fill[list_idx] - 1)];
			default: ;
		endcase
		return $urandom;
	endfunction

	task automatic test_directed();
		send_word(F_COUNT, 4'd0, 0, 0);
		send_word(F_READ, 4'd15, 0, 0);
		send_word(F_CREATE, 4'd11, 7'sd4, 0);
		send_word(F_APPEND, 4'd1, 0, 32'd5);
		send_word(F_CREATE, 4'd1, 7'sd0, 0);
		send_word(F_CREATE, 4'd1, -7'sd64, 0);
		send_word(F_CREATE, 4'd1, 7'sd17, 0);
		send_word(F_CREATE, 4'd1, 7'sd63, 0);
		send_word(F_CREATE, 4'd1, 7'sd2, 0);
		send_word(F_CREATE, 4'd1, 7'sd2, 0);
		send_word(F_COUNT, 4'd1, 0, 0);
		send_word(F_DROP, 4'd1, 0, 0);
		send_word(F_DELETE, 4'd1, 0, 0);
		send_word(F_READ, 4'd1, 0, 0);
		send_word(F_APPEND, 4'd1, 0, 32'h7fffffff);
		send_word(F_APPEND, 4'd1, 0, 32'h80000000);
		send_word(F_APPEND, 4'd1, 0, 32'hffffffff);
		send_word(F_SORTED, 4'd1, 0, 0);
		send_word(F_DELETE, 4'd1, 0, 32'd1);
		send_word(F_RESIZE, 4'd1, -7'sd2, 0);
		send_word(F_RESIZE, 4'd1, 7'sd15, 0);
		send_word(F_RESIZE, 4'd1, 7'sd14, 0);
		send_word(F_CREATE, 4'd10, 7'sd16, 0);
		send_word(F_RESIZE, 4'd1, -7'sd1, 0);
		send_word(F_READ, 4'd1, 0, 0);
	endtask

	task automatic test_random(input int count);
		int k, li, roll;
		logic [2:0] f;
		logic [3:0] pos;
		logic signed [6:0] amt;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			pos = (roll < 5) ? 4'($urandom_range(15)) : 4'($urandom_range(NUM_LISTS, 1));
			li = (pos >= 1 && pos <= NUM_LISTS) ? pos - 1 : 0;
			if (roll < 45 && shadow_present[li])
				f = F_APPEND;
			else
				f = 3'($urandom_range(7));
			amt = (f == F_CREATE) ? 7'($urandom_range(17)) : 7'($urandom_range(40)) - 7'sd20;
			if ($urandom_range(19) == 0)
				amt = 7'($urandom);
			if (f == F_CREATE && shadow_present[li] && $urandom_range(3) == 0)
				send_word(F_DROP, pos, 0, 0);
			send_word(f, pos, amt, pick_value(li));
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < NUM_LISTS; i++) begin
			shadow_present[i] = 0;
			shadow_cap[i] = 0;
			shadow_fill[i] = 0;
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 20;
		recv_idle_pct = 65;
		test_directed();
		test_random(110);
		send_idle_pct = 65;
		recv_idle_pct = 20;
		test_random(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(115);
		drain();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: sim.f
rtl/core/mls_pkg.sv
rtl/core/mls_ram.sv
rtl/core/mls_front.sv
rtl/core/mls_queue.sv
rtl/core/mls_back.sv
rtl/core/multi_list_store_top.sv
test/multi_list_store_top_test.sv
